@@ rtl/core/trm_pkg.sv @@
`timescale 1ns / 1ps

package trm_pkg;

    // map and table limits
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_RECTS   = 256;

    // cells are grouped so that the hit flag and the read mux are registered per group
    localparam int GROUP_SIZE  = 16;
    localparam int GROUP_COUNT = MAX_RECTS / GROUP_SIZE;
    localparam int LANE_W      = $clog2(GROUP_SIZE);
    localparam int GRP_W       = $clog2(GROUP_COUNT);

    // field widths
    localparam int CMD_W  = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int SIZE_W = 7;
    localparam int KEY_W  = 8;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;

    localparam logic [KEY_W-1:0] BLANK_KEY = 8'd32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [KEY_W-1:0]  key;
    } trm_rect_t;

    // broadcast from the controller to every table cell
    typedef struct packed {
        logic [COL_W-1:0]  run_start;
        logic [KEY_W-1:0]  run_char;
        logic [SIZE_W-1:0] run_length;
        logic [ROW_W-1:0]  cur_row;
        logic [CNT_W-1:0]  count;
        logic              match_en;
        logic              commit_en;
        logic              append_en;
    } trm_bus_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTEND,
        ST_MATCH,
        ST_REDUCE,
        ST_COMMIT,
        ST_READ,
        ST_RESP
    } trm_state_t;

endpackage

@@ rtl/core/trm_cell.sv @@
`timescale 1ns / 1ps

module trm_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  trm_pkg::trm_bus_t           bus,
    input  logic [trm_pkg::IDX_W-1:0]   slot,
    input  logic                        hit_in,
    output logic                        hit_out,
    output trm_pkg::trm_rect_t          rect_out
);

    trm_pkg::trm_rect_t              rect_reg;
    logic                            match_reg;
    logic                            active;
    logic                            slot_is_tail;
    logic [trm_pkg::ROW_W-1:0]       row_diff;
    logic                            match_next;

    assign active       = {1'b0, slot} < bus.count;
    assign slot_is_tail = {1'b0, slot} == bus.count;

    always_comb begin
        if (bus.cur_row >= rect_reg.row) begin
            row_diff = bus.cur_row - rect_reg.row;
        end else begin
            row_diff = rect_reg.row - bus.cur_row;
        end
        match_next = active
                     && (rect_reg.col == bus.run_start)
                     && (rect_reg.key == bus.run_char)
                     && (rect_reg.width == bus.run_length)
                     && ({1'b0, row_diff} <= rect_reg.height);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (bus.match_en) begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bus.commit_en) begin
            if (bus.append_en && slot_is_tail) begin
                rect_reg.col    <= bus.run_start;
                rect_reg.row    <= bus.cur_row;
                rect_reg.width  <= bus.run_length;
                rect_reg.height <= trm_pkg::SIZE_W'(1);
                rect_reg.key    <= bus.run_char;
            end else if (match_reg
                         && rect_reg.height < trm_pkg::SIZE_W'(trm_pkg::MAX_ROWS)) begin
                rect_reg.height <= rect_reg.height + trm_pkg::SIZE_W'(1);
            end
        end
    end

    // hit flag ripples along the row of cells
    assign hit_out  = hit_in | match_reg;
    assign rect_out = rect_reg;

endmodule

@@ rtl/core/trm_group.sv @@
`timescale 1ns / 1ps

module trm_group (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  trm_pkg::trm_bus_t           bus,
    input  logic [trm_pkg::GRP_W-1:0]   grp_num,
    input  logic [trm_pkg::LANE_W-1:0]  rd_lane,
    output logic                        grp_hit,
    output trm_pkg::trm_rect_t          grp_rect
);

    logic [trm_pkg::GROUP_SIZE:0] hit_chain;
    trm_pkg::trm_rect_t           cell_rect [trm_pkg::GROUP_SIZE];
    logic                         grp_hit_reg;
    trm_pkg::trm_rect_t           grp_rect_reg;

    assign hit_chain[0] = 1'b0;

    for (genvar lane = 0; lane < trm_pkg::GROUP_SIZE; lane++) begin : g_cell
        trm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bus      (bus),
            .slot     ({grp_num, trm_pkg::LANE_W'(lane)}),
            .hit_in   (hit_chain[lane]),
            .hit_out  (hit_chain[lane+1]),
            .rect_out (cell_rect[lane])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_hit_reg <= 1'b0;
        end else begin
            grp_hit_reg <= hit_chain[trm_pkg::GROUP_SIZE];
        end
    end

    always_ff @(posedge aclk) begin
        grp_rect_reg <= cell_rect[rd_lane];
    end

    assign grp_hit  = grp_hit_reg;
    assign grp_rect = grp_rect_reg;

endmodule

@@ rtl/core/tile_run_rectangle_merge_top.sv @@
`timescale 1ns / 1ps

// channel  | direction | transfer carries
// ---------+-----------+------------------------------------------------------------
// s_       | in        | command, cell_key, read_index
// m_       | out       | rect_col/row/width/height/key, entry_valid, rect_count, overflow
// cfg_     | in        | map_cols (cells per row), write data only
//
// a push that closes no run is handled in the idle state; each run closure passes through
//   match in the cells, registered group hit reduce and commit, and a closure on a key change
//   then passes through the extend state to open the new run
// a read passes through accept, registered group read mux, final mux into the output register
// aresetn is synchronous and active low; map_cols resets to 64, the table contents stay undefined
// a finished read waits in the output register while the input side keeps working; the block
//   holds in the response state only when the previous result has not been taken yet

module tile_run_rectangle_merge_top (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [trm_pkg::CMD_W-1:0]   s_command,
    input  logic [trm_pkg::KEY_W-1:0]   s_cell_key,
    input  logic [trm_pkg::IDX_W-1:0]   s_read_index,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [trm_pkg::COL_W-1:0]   m_rect_col,
    output logic [trm_pkg::ROW_W-1:0]   m_rect_row,
    output logic [trm_pkg::SIZE_W-1:0]  m_rect_width,
    output logic [trm_pkg::SIZE_W-1:0]  m_rect_height,
    output logic [trm_pkg::KEY_W-1:0]   m_rect_key,
    output logic                        m_entry_valid,
    output logic [trm_pkg::CNT_W-1:0]   m_rect_count,
    output logic                        m_overflow,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [trm_pkg::SIZE_W-1:0]  cfg_wdata
);

    // control state
    trm_pkg::trm_state_t             state_reg, state_next;
    logic [trm_pkg::SIZE_W-1:0]      map_cols_reg;
    logic [trm_pkg::COL_W-1:0]       run_start_reg, run_start_next;
    logic [trm_pkg::KEY_W-1:0]       run_char_reg, run_char_next;
    logic [trm_pkg::SIZE_W-1:0]      run_len_reg, run_len_next;
    logic [trm_pkg::COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [trm_pkg::ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [trm_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            overflow_reg, overflow_next;
    logic                            last_close_reg, last_close_next;
    logic                            m_valid_reg, m_valid_next;

    // latched input payload
    logic [trm_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [trm_pkg::IDX_W-1:0]       idx_reg, idx_next;

    // result register
    trm_pkg::trm_rect_t              out_rect_reg, out_rect_next;
    logic                            out_entry_valid_reg, out_entry_valid_next;
    logic [trm_pkg::CNT_W-1:0]       out_count_reg, out_count_next;
    logic                            out_overflow_reg, out_overflow_next;

    // cell array interface
    trm_pkg::trm_bus_t               bus;
    logic                            append_en;
    logic [trm_pkg::GROUP_COUNT-1:0] grp_hit;
    trm_pkg::trm_rect_t              grp_rect [trm_pkg::GROUP_COUNT];
    logic                            any_hit;

    // helpers
    logic [trm_pkg::SIZE_W-1:0]      cols;
    logic                            end_row;
    logic [trm_pkg::ROW_W-1:0]       row_inc;
    logic [trm_pkg::KEY_W-1:0]       ext_key;
    logic [trm_pkg::COL_W-1:0]       ext_start;
    logic [trm_pkg::KEY_W-1:0]       ext_char;
    logic [trm_pkg::SIZE_W-1:0]      ext_len;
    logic                            do_extend;
    logic                            rd_hit;

    // configuration write port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_cols_reg <= trm_pkg::SIZE_W'(trm_pkg::MAX_COLS);
        end else if (cfg_valid) begin
            map_cols_reg <= cfg_wdata;
        end
    end

    // effective row length: zero acts as one, oversize clamps to the map limit
    always_comb begin
        if (map_cols_reg == '0) begin
            cols = trm_pkg::SIZE_W'(1);
        end else if (map_cols_reg > trm_pkg::SIZE_W'(trm_pkg::MAX_COLS)) begin
            cols = trm_pkg::SIZE_W'(trm_pkg::MAX_COLS);
        end else begin
            cols = map_cols_reg;
        end
    end

    assign end_row = ({1'b0, cur_col_reg} + trm_pkg::SIZE_W'(1)) >= cols;
    assign row_inc = (({1'b0, cur_row_reg} + trm_pkg::SIZE_W'(1))
                      >= trm_pkg::SIZE_W'(trm_pkg::MAX_ROWS))
                     ? '0 : cur_row_reg + trm_pkg::ROW_W'(1);

    // run update for the pushed cell; the key comes straight from the port on a
    // push taken in the idle state, else from the latched copy after a closure
    assign ext_key = (state_reg == trm_pkg::ST_IDLE) ? s_cell_key : key_reg;

    always_comb begin
        ext_start = run_start_reg;
        ext_char  = run_char_reg;
        ext_len   = run_len_reg;
        if (ext_key != trm_pkg::BLANK_KEY) begin
            if (run_len_reg == '0) begin
                ext_start = cur_col_reg;
                ext_char  = ext_key;
                ext_len   = trm_pkg::SIZE_W'(1);
            end else begin
                ext_len   = run_len_reg + trm_pkg::SIZE_W'(1);
            end
        end
    end

    // table cells, grouped for the registered hit reduce and read mux
    always_comb begin
        bus.run_start  = run_start_reg;
        bus.run_char   = run_char_reg;
        bus.run_length = run_len_reg;
        bus.cur_row    = cur_row_reg;
        bus.count      = count_reg;
        bus.match_en   = (state_reg == trm_pkg::ST_MATCH);
        bus.commit_en  = (state_reg == trm_pkg::ST_COMMIT);
        bus.append_en  = append_en;
    end

    for (genvar g = 0; g < trm_pkg::GROUP_COUNT; g++) begin : g_group
        trm_group u_group (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bus      (bus),
            .grp_num  (trm_pkg::GRP_W'(g)),
            .rd_lane  (idx_reg[trm_pkg::LANE_W-1:0]),
            .grp_hit  (grp_hit[g]),
            .grp_rect (grp_rect[g])
        );
    end

    assign any_hit = |grp_hit;
    assign rd_hit  = {1'b0, idx_reg} < count_reg;

    // sequencer
    always_comb begin
        state_next           = state_reg;
        run_start_next       = run_start_reg;
        run_char_next        = run_char_reg;
        run_len_next         = run_len_reg;
        cur_col_next         = cur_col_reg;
        cur_row_next         = cur_row_reg;
        count_next           = count_reg;
        overflow_next        = overflow_reg;
        last_close_next      = last_close_reg;
        key_next             = key_reg;
        idx_next             = idx_reg;
        out_rect_next        = out_rect_reg;
        out_entry_valid_next = out_entry_valid_reg;
        out_count_next       = out_count_reg;
        out_overflow_next    = out_overflow_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        append_en            = 1'b0;
        do_extend            = 1'b0;
        s_ready              = (state_reg == trm_pkg::ST_IDLE);

        unique case (state_reg)
            trm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_cell_key;
                    idx_next = s_read_index;
                    unique case (s_command)
                        trm_pkg::CMD_CLEAR: begin
                            // map_cols survives a clear
                            run_start_next = '0;
                            run_char_next  = '0;
                            run_len_next   = '0;
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            count_next     = '0;
                            overflow_next  = 1'b0;
                        end
                        trm_pkg::CMD_PUSH: begin
                            if (run_len_reg != '0 && s_cell_key != run_char_reg) begin
                                // key change closes the open run first
                                last_close_next = 1'b0;
                                state_next      = trm_pkg::ST_MATCH;
                            end else begin
                                do_extend = 1'b1;
                            end
                        end
                        trm_pkg::CMD_READ: begin
                            state_next = trm_pkg::ST_READ;
                        end
                        default: begin
                            // unused command code, dropped
                        end
                    endcase
                end
            end
            trm_pkg::ST_EXTEND: begin
                do_extend = 1'b1;
            end
            trm_pkg::ST_MATCH: begin
                state_next = trm_pkg::ST_REDUCE;
            end
            trm_pkg::ST_REDUCE: begin
                state_next = trm_pkg::ST_COMMIT;
            end
            trm_pkg::ST_COMMIT: begin
                // matching cells grow themselves; a run nobody took is appended or dropped
                if (!any_hit) begin
                    if (count_reg < trm_pkg::CNT_W'(trm_pkg::MAX_RECTS)) begin
                        append_en  = 1'b1;
                        count_next = count_reg + trm_pkg::CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                run_len_next = '0;
                if (last_close_reg) begin
                    cur_col_next = '0;
                    cur_row_next = row_inc;
                    state_next   = trm_pkg::ST_IDLE;
                end else begin
                    state_next   = trm_pkg::ST_EXTEND;
                end
            end
            trm_pkg::ST_READ: begin
                state_next = trm_pkg::ST_RESP;
            end
            trm_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    if (rd_hit) begin
                        out_rect_next = grp_rect[idx_reg[trm_pkg::IDX_W-1:trm_pkg::LANE_W]];
                    end else begin
                        out_rect_next = '0;
                    end
                    out_entry_valid_next = rd_hit;
                    out_count_next       = count_reg;
                    out_overflow_next    = overflow_reg;
                    m_valid_next         = 1'b1;
                    state_next           = trm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = trm_pkg::ST_IDLE;
            end
        endcase

        // take the cell into the run, then step the column, or at row end close the open run or wrap the row
        if (do_extend) begin
            run_start_next = ext_start;
            run_char_next  = ext_char;
            run_len_next   = ext_len;
            if (end_row) begin
                if (ext_len != '0) begin
                    last_close_next = 1'b1;
                    state_next      = trm_pkg::ST_MATCH;
                end else begin
                    cur_col_next = '0;
                    cur_row_next = row_inc;
                    state_next   = trm_pkg::ST_IDLE;
                end
            end else begin
                cur_col_next = cur_col_reg + trm_pkg::COL_W'(1);
                state_next   = trm_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= trm_pkg::ST_IDLE;
            run_start_reg  <= '0;
            run_char_reg   <= '0;
            run_len_reg    <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            last_close_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_start_reg  <= run_start_next;
            run_char_reg   <= run_char_next;
            run_len_reg    <= run_len_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            last_close_reg <= last_close_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg             <= key_next;
        idx_reg             <= idx_next;
        out_rect_reg        <= out_rect_next;
        out_entry_valid_reg <= out_entry_valid_next;
        out_count_reg       <= out_count_next;
        out_overflow_reg    <= out_overflow_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_rect_col    = out_rect_reg.col;
    assign m_rect_row    = out_rect_reg.row;
    assign m_rect_width  = out_rect_reg.width;
    assign m_rect_height = out_rect_reg.height;
    assign m_rect_key    = out_rect_reg.key;
    assign m_entry_valid = out_entry_valid_reg;
    assign m_rect_count  = out_count_reg;
    assign m_overflow    = out_overflow_reg;

    // overflow is only ever raised against a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(overflow_reg) |-> count_reg == trm_pkg::CNT_W'(trm_pkg::MAX_RECTS))
        else $error("overflow raised while the table had room");

    // the table never holds more than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= trm_pkg::CNT_W'(trm_pkg::MAX_RECTS))
        else $error("rectangle count beyond table size");

    // the count grows by one, and only out of a commit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > $past(count_reg)) |->
            ($past(state_reg == trm_pkg::ST_COMMIT)
             && count_reg == $past(count_reg) + trm_pkg::CNT_W'(1)))
        else $error("rectangle count stepped outside a commit");

    // a commit always follows the registered hit reduce
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == trm_pkg::ST_COMMIT |-> $past(state_reg == trm_pkg::ST_REDUCE))
        else $error("commit without a completed hit reduce");

    // results appear only out of the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == trm_pkg::ST_RESP))
        else $error("result presented outside a read");

endmodule
